### design/cpam_pkg.sv
// ----------------------------------------------------------------------------
// cpam_pkg: shared types and constants
// Field widths, register codes, controller states and the command/status
// bundles between the card presence controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpam_pkg;

   // field widths
   localparam int CARD_ID_W  = 32;
   localparam int SLOT_W     = 5;
   localparam int MISS_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;
   // wide enough to hold any slot number and any table depth up to 256
   localparam int SPAN_W     = 9;

   // miss counter ceiling and register reset values
   localparam logic [MISS_W-1:0] MISS_MAX       = 4'hF;
   localparam logic [MISS_W-1:0] MISS_LIMIT_RST = 4'd2;
   localparam logic              READER_EN_RST  = 1'b1;

   // request kinds
   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MISS_LIMIT = 1'b0,
      CSR_READER_EN  = 1'b1
   } csr_reg_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_SETTLE,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_wr;    // write the requested table slot
      logic scan_take;  // capture scan fields, rewind the table walk
      logic walk_rd;    // read the current table entry and advance
      logic finish;     // update tracking state and load the response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_load;   // offered request is a table load
      logic req_hit;    // offered scan counts as a detection
      logic walk_last;  // walk address is on the last entry
      logic out_free;   // response register can take a new result
   } stat_type;

endpackage

`default_nettype wire

### design/cpam_if.sv
// ----------------------------------------------------------------------------
// cpam_if: channel interfaces
// Request, response and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cpam_req_if;
   import cpam_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic                 detected;
   logic [CARD_ID_W-1:0] card_id;
   logic [SLOT_W-1:0]    entry_index;
   logic [CARD_ID_W-1:0] entry_id;

   modport source (output valid, cmd, detected, card_id, entry_index, entry_id,
                   input ready);
   modport sink   (input valid, cmd, detected, card_id, entry_index, entry_id,
                   output ready);
endinterface

interface cpam_rsp_if;
   logic valid;
   logic ready;
   logic present;
   logic entering;
   logic new_id;
   logic valid_res;

   modport source (output valid, present, entering, new_id, valid_res,
                   input ready);
   modport sink   (input valid, present, entering, new_id, valid_res,
                   output ready);
endinterface

interface cpam_csr_if;
   import cpam_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/cpam_ctrl.sv
// ----------------------------------------------------------------------------
// cpam_ctrl: request sequencer
// Accepts requests, runs the table walk for detected scans and hands the
// finished result to the response register when it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpam_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cpam_pkg::stat_type stat_i,
   output cpam_pkg::cmd_type      cmd_o
);
   import cpam_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stat_i.req_load) begin
               state_in = stat_i.req_hit ? ST_WALK : ST_FINISH;
            end
         end
         ST_WALK: begin
            if (stat_i.walk_last) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat_i.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd_o     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd_o.load_wr   = req_valid && stat_i.req_load;
            cmd_o.scan_take = req_valid && !stat_i.req_load;
         end
         ST_WALK: begin
            cmd_o.walk_rd = 1'b1;
         end
         ST_SETTLE: begin
         end
         ST_FINISH: begin
            cmd_o.finish = stat_i.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### design/cpam_dp.sv
// ----------------------------------------------------------------------------
// cpam_dp: table, presence tracking and response register
// Holds the allowed-ID table, walks it one entry a cycle for a match,
// keeps the debounce state and the configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpam_dp #(
   parameter int ENTRIES = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   cpam_req_if.sink                req_ch,
   cpam_rsp_if.source              rsp_ch,
   cpam_csr_if.sink                csr_ch,
   input  wire cpam_pkg::cmd_type  cmd_i,
   output cpam_pkg::stat_type      stat_o
);
   import cpam_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // table storage, entry valid bits cleared at reset
   logic [CARD_ID_W-1:0] mem [ENTRIES];
   logic [ENTRIES-1:0]   vld_ff;

   // walk
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic [CARD_ID_W-1:0] rd_data_ff;
   logic                 rd_live_ff;
   logic                 cmp_pend_ff;
   logic                 match_ff, match_in;

   // captured scan
   logic                 hit_ff;
   logic [CARD_ID_W-1:0] id_ff;

   // tracking state and configuration
   logic [CARD_ID_W-1:0] last_id_ff, last_id_in;
   logic                 card_here_ff, card_here_in;
   logic [MISS_W-1:0]    miss_run_ff, miss_run_in;
   logic [MISS_W-1:0]    miss_limit_ff;
   logic                 reader_en_ff;

   // response register
   logic                 rsp_valid_ff;
   logic                 present_ff, entering_ff, new_id_ff, valid_res_ff;
   logic                 entering_in, new_id_in;

   // slot decode for loads
   logic [SPAN_W-1:0]    slot_wide;
   logic                 slot_ok;
   logic [IDX_W-1:0]     wr_addr;

   assign slot_wide = SPAN_W'(req_ch.entry_index);
   assign slot_ok   = slot_wide < SPAN_W'(ENTRIES);
   assign wr_addr   = slot_wide[IDX_W-1:0];

   // status to the controller
   assign stat_o.req_load  = (req_ch.cmd == CMD_LOAD);
   assign stat_o.req_hit   = req_ch.detected && reader_en_ff;
   assign stat_o.walk_last = (addr_ff == IDX_W'(ENTRIES - 1));
   assign stat_o.out_free  = !rsp_valid_ff || rsp_ch.ready;

   // configuration writes
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         miss_limit_ff <= MISS_LIMIT_RST;
         reader_en_ff  <= READER_EN_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_MISS_LIMIT: miss_limit_ff <= csr_ch.data;
            CSR_READER_EN:  reader_en_ff  <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   // table write port
   always_ff @(posedge clock) begin
      if (cmd_i.load_wr && slot_ok) begin
         mem[wr_addr] <= req_ch.entry_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd_i.load_wr && slot_ok) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // table read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[addr_ff];
      rd_live_ff <= vld_ff[addr_ff];
   end

   // walk address and match accumulation
   always_comb begin
      addr_in  = addr_ff;
      match_in = match_ff;
      if (cmd_i.scan_take) begin
         addr_in  = '0;
         match_in = 1'b0;
      end else begin
         if (cmd_i.walk_rd) begin
            addr_in = addr_ff + IDX_W'(1);
         end
         if (cmp_pend_ff && rd_live_ff && (rd_data_ff != '0) && (rd_data_ff == id_ff)) begin
            match_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         match_ff    <= 1'b0;
         cmp_pend_ff <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         match_ff    <= match_in;
         cmp_pend_ff <= cmd_i.walk_rd;
      end
   end

   // scan capture
   always_ff @(posedge clock) begin
      if (cmd_i.scan_take) begin
         hit_ff <= stat_o.req_hit;
         id_ff  <= req_ch.card_id;
      end
   end

   // presence debounce and id tracking
   always_comb begin
      last_id_in   = last_id_ff;
      card_here_in = card_here_ff;
      miss_run_in  = miss_run_ff;
      entering_in  = 1'b0;
      new_id_in    = 1'b0;
      if (hit_ff) begin
         miss_run_in  = '0;
         entering_in  = !card_here_ff;
         card_here_in = 1'b1;
         new_id_in    = (id_ff != last_id_ff);
         last_id_in   = id_ff;
      end else begin
         if (miss_run_ff < MISS_MAX) begin
            miss_run_in = miss_run_ff + MISS_W'(1);
         end
         if (miss_run_in > miss_limit_ff) begin
            card_here_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_id_ff   <= '0;
         card_here_ff <= 1'b0;
         miss_run_ff  <= '0;
      end else if (cmd_i.finish) begin
         last_id_ff   <= last_id_in;
         card_here_ff <= card_here_in;
         miss_run_ff  <= miss_run_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.finish) begin
         present_ff   <= card_here_in;
         entering_ff  <= entering_in;
         new_id_ff    <= new_id_in;
         valid_res_ff <= hit_ff && match_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.present   = present_ff;
   assign rsp_ch.entering  = entering_ff;
   assign rsp_ch.new_id    = new_id_ff;
   assign rsp_ch.valid_res = valid_res_ff;

`ifndef SYNTH
   // a card just entering is always reported as present
   a_enter_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && entering_ff |-> present_ff)
      else $error("entering reported without presence");

   // a table match only comes with a present card
   a_match_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && valid_res_ff |-> present_ff)
      else $error("match reported without presence");

   // a finished scan always shows up on the response side
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd_i.finish |=> rsp_valid_ff)
      else $error("finished scan did not load the response");
`endif

endmodule

`default_nettype wire

### design/card_presence_access_matcher.sv
// ----------------------------------------------------------------------------
// card_presence_access_matcher: card presence tracker and access list check
// Debounces card presence over periodic scans and looks each detected ID
// up in a table of allowed IDs loaded over the request channel.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries either a table load (cmd 1: entry_index, entry_id) or a
//    scan (cmd 0: detected, card_id). A load is written in the cycle it is
//    accepted and gives no response; slots at or above ENTRIES are ignored.
//  - rsp_ch returns one response per scan: present, entering, new_id and
//    valid_res, held in an output register until taken.
//  - csr_ch writes miss_limit (index 0) and reader_enable (index 1); it is
//    always ready and should be written only while no scan is in flight.
//  - a detected scan walks the table one entry a cycle through the single
//    read port of the table memory, then passes a settle state before its
//    result is loaded; a missed scan goes straight to the finish state.
//  - a new request is taken once the previous scan has reached the output
//    register or the previous load has been written, so no new scan is
//    taken before the last one is through; if rsp_ch stalls, a finished
//    scan waits in its last state.
//  - reset clears the table (entry valid bits), the tracking state and the
//    response register, and restores the register defaults (2 and 1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module card_presence_access_matcher #(
   parameter int ENTRIES = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cpam_req_if.sink   req_ch,
   cpam_rsp_if.source rsp_ch,
   cpam_csr_if.sink   csr_ch
);
   import cpam_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   cpam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   // table, tracking state and response register
   cpam_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd_i  (cmd),
      .stat_o (stat)
   );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the card presence access matcher
// Sends table loads and scan requests with random gaps and response stalls,
// predicts every scan response from a behavioural copy of the presence
// tracker and access table, and checks the responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import cpam_pkg::*;

   localparam int NUM_SLOTS     = 32;
   // a detected scan walks the whole table; allow a margin on top
   localparam int SETTLE_CYCLES = NUM_SLOTS + 8;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic                 cmd;
      logic                 detected;
      logic [CARD_ID_W-1:0] card_id;
      logic [SLOT_W-1:0]    entry_index;
      logic [CARD_ID_W-1:0] entry_id;
   } access_req_type;

   typedef struct packed {
      logic present;
      logic entering;
      logic new_id;
      logic valid_res;
   } scan_flags_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // driven channel values
   logic                  req_valid = 1'b0;
   access_req_type        req_item  = '0;
   logic                  rsp_rdy   = 1'b0;
   logic                  csr_valid = 1'b0;
   csr_reg_type           csr_index = CSR_MISS_LIMIT;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // idling and hold-off controls
   bit req_gaps_on   = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int hold_len      = 0;
   bit hold_go       = 1'b0;
   bit hold_seen     = 1'b0;
   int rsp_stall     = 0;

   // predicted tracker state and register copies
   logic [CARD_ID_W-1:0] allow_list [NUM_SLOTS];
   logic [CARD_ID_W-1:0] last_card;
   logic                 card_held;
   logic [MISS_W-1:0]    miss_run_cnt;
   logic [MISS_W-1:0]    miss_limit_cfg;
   logic                 reader_on;

   scan_flags_type expected_flags [$];
   int             mismatch_count = 0;

   cpam_req_if req_ch ();
   cpam_rsp_if rsp_ch ();
   cpam_csr_if csr_ch ();

   assign req_ch.valid       = req_valid;
   assign req_ch.cmd         = req_item.cmd;
   assign req_ch.detected    = req_item.detected;
   assign req_ch.card_id     = req_item.card_id;
   assign req_ch.entry_index = req_item.entry_index;
   assign req_ch.entry_id    = req_item.entry_id;
   assign rsp_ch.ready       = rsp_rdy;
   assign csr_ch.valid       = csr_valid;
   assign csr_ch.index       = csr_index;
   assign csr_ch.data        = csr_data;

   card_presence_access_matcher #(
      .ENTRIES(NUM_SLOTS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // apply one accepted request to the tracker copy, queue the scan flags
   function automatic void track_request(input access_req_type r);
      scan_flags_type f;
      f = '0;
      if (r.cmd == CMD_LOAD) begin
         if (r.entry_index < NUM_SLOTS) allow_list[r.entry_index] = r.entry_id;
      end else begin
         if (r.detected && reader_on) begin
            miss_run_cnt = '0;
            f.entering   = !card_held;
            card_held    = 1'b1;
            f.new_id     = (r.card_id != last_card);
            last_card    = r.card_id;
            // empty slots hold zero and never match
            foreach (allow_list[i])
               if (allow_list[i] != '0 && allow_list[i] == r.card_id) f.valid_res = 1'b1;
         end else begin
            if (miss_run_cnt != MISS_MAX) miss_run_cnt++;
            if (miss_run_cnt > miss_limit_cfg) card_held = 1'b0;
         end
         f.present = card_held;
         expected_flags.push_back(f);
      end
   endfunction

   // ------------------------------------------------------------------------
   // request builders
   // ------------------------------------------------------------------------

   // unused load fields carry random bits
   function automatic access_req_type scan_req(input logic det,
                                               input logic [CARD_ID_W-1:0] id);
      access_req_type r;
      r.cmd         = CMD_SCAN;
      r.detected    = det;
      r.card_id     = id;
      r.entry_index = SLOT_W'($urandom());
      r.entry_id    = $urandom();
      return r;
   endfunction

   // unused scan fields carry random bits
   function automatic access_req_type load_req(input logic [SLOT_W-1:0] slot,
                                               input logic [CARD_ID_W-1:0] id);
      access_req_type r;
      r.cmd         = CMD_LOAD;
      r.detected    = 1'($urandom());
      r.card_id     = $urandom();
      r.entry_index = slot;
      r.entry_id    = id;
      return r;
   endfunction

   // mostly listed ids, some repeats of the last card and some extremes
   function automatic logic [CARD_ID_W-1:0] pick_card_id();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return allow_list[$urandom_range(0, NUM_SLOTS - 1)];
         6:                return last_card;
         7:                return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         default:          return $urandom();
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // channel drivers
   // ------------------------------------------------------------------------

   // offer one request after a random gap; valid stays high for the next one
   task automatic send_request(input access_req_type r);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      track_request(r);
   endtask

   // stop offering and let every outstanding scan come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_flags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      case (idx)
         CSR_MISS_LIMIT: miss_limit_cfg = val[MISS_W-1:0];
         CSR_READER_EN:  reader_on      = val[0];
         default:        ;
      endcase
   endtask

   // write both registers back to back, only while the block is idle
   task automatic configure(input logic [MISS_W-1:0] limit, input logic enable);
      csr_put(CSR_MISS_LIMIT, limit);
      csr_put(CSR_READER_EN, {{(CSR_DATA_W - 1){1'b0}}, enable});
      csr_valid <= 1'b0;
   endtask

   // response ready: random stall after each response, long hold on demand
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_rdy   <= 1'b0;
         rsp_stall <= 0;
      end else if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         rsp_stall <= hold_len;
         rsp_rdy   <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_rdy   <= (rsp_stall == 1);
      end else if (rsp_ch.valid && rsp_rdy) begin
         n = rsp_stalls_on ? $urandom_range(0, 9) : 0;
         rsp_stall <= n;
         rsp_rdy   <= (n == 0);
      end else begin
         rsp_rdy <= 1'b1;
      end
   end

   // compare each response with the oldest expected scan flags
   always @(posedge clock) begin
      scan_flags_type got;
      scan_flags_type want;
      if (!reset && rsp_ch.valid && rsp_rdy) begin
         got = {rsp_ch.present, rsp_ch.entering, rsp_ch.new_id, rsp_ch.valid_res};
         if (expected_flags.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: response with no scan outstanding: %s %b %b %b %b",
                        $time, "present entering new_id valid_res", got.present,
                        got.entering, got.new_id, got.valid_res);
         end else begin
            want = expected_flags.pop_front();
            if (got.present != want.present || got.entering != want.entering ||
                got.new_id != want.new_id || got.valid_res != want.valid_res) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: scan flags expected p%b e%b n%b v%b, got p%b e%b n%b v%b",
                           $time, want.present, want.entering, want.new_id,
                           want.valid_res, got.present, got.entering, got.new_id,
                           got.valid_res);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // table matching on reset defaults
   task automatic test_access_table();
      // empty table, last id starts at zero
      send_request(scan_req(1'b1, 32'h0));
      send_request(scan_req(1'b1, 32'hFFFF_FFFF));
      send_request(load_req(5'd0, 32'hFFFF_FFFF));
      send_request(load_req(5'd31, 32'h0000_0001));
      send_request(scan_req(1'b1, 32'hFFFF_FFFF));
      send_request(scan_req(1'b1, 32'h0000_0001));
      // writing zero empties the slot again
      send_request(load_req(5'd31, 32'h0));
      send_request(scan_req(1'b1, 32'h0000_0001));
      // an id of zero never matches an empty slot
      send_request(scan_req(1'b1, 32'h0));
   endtask

   // presence debounce, zero miss limit and disabled reader
   task automatic test_miss_debounce();
      // default limit of two: the third miss drops the card
      repeat (3) send_request(scan_req(1'b0, $urandom()));
      send_request(scan_req(1'b1, 32'h0));
      wait_drained();
      configure(4'd0, 1'b1);
      send_request(scan_req(1'b0, 32'hFFFF_FFFF));
      send_request(scan_req(1'b1, 32'h8000_0000));
      // reader off: detections count as misses, loads still land
      wait_drained();
      configure(4'd2, 1'b0);
      send_request(scan_req(1'b1, 32'h8000_0000));
      send_request(load_req(5'd16, 32'h8000_0000));
      repeat (2) send_request(scan_req(1'b1, 32'h8000_0000));
   endtask

   // receiver holds off while requests keep coming, then sender waits
   task automatic test_output_backpressure();
      wait_drained();
      configure(4'd3, 1'b1);
      req_gaps_on = 1'b0;
      hold_len <= 300;
      hold_go  <= !hold_go;
      repeat (12) send_request(scan_req(1'($urandom_range(0, 1)), pick_card_id()));
      wait_drained();
      req_gaps_on = 1'b1;
   endtask

   // random card sessions, table updates and noise for one setting
   task automatic run_sessions(input int budget);
      int                   sent;
      int                   roll;
      int                   hits;
      int                   misses;
      logic [CARD_ID_W-1:0] id;
      sent = 0;
      while (sent < budget) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // noise: any field pattern
            if ($urandom_range(0, 1) != 0)
               send_request(load_req(SLOT_W'($urandom()), $urandom()));
            else
               send_request(scan_req(1'($urandom()), $urandom()));
            sent++;
         end else if (roll < 18) begin
            // table update, sometimes emptying a slot
            id = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
            send_request(load_req(SLOT_W'($urandom()), id));
            sent++;
         end else begin
            // card session: detection bursts split by miss runs around the limit
            id = pick_card_id();
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 4) == 0) id = pick_card_id();
               hits   = $urandom_range(1, 4);
               misses = $urandom_range(0, miss_limit_cfg + 3);
               repeat (hits) send_request(scan_req(1'b1, id));
               repeat (misses) send_request(scan_req(1'b0, $urandom()));
               sent += hits + misses;
            end
         end
      end
   endtask

   // random traffic over a series of register settings
   task automatic test_random_traffic();
      int                ph;
      logic [MISS_W-1:0] limit;
      logic              enable;
      // fill part of the table so sessions find listed cards
      repeat (16) send_request(load_req(SLOT_W'($urandom()), $urandom()));
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               limit  = 4'd0;
               enable = 1'b1;
            end
            1: begin
               limit  = MISS_MAX;
               enable = 1'b1;
            end
            2: begin
               limit  = MISS_W'($urandom());
               enable = 1'b0;
            end
            default: begin
               limit  = MISS_W'($urandom());
               enable = ($urandom_range(0, 4) != 0);
            end
         endcase
         wait_drained();
         configure(limit, enable);
         req_gaps_on   = (ph % 3 != 1);
         rsp_stalls_on = (ph % 3 != 2);
         run_sessions((ph == 2) ? 60 : 140);
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin
      foreach (allow_list[i]) allow_list[i] = '0;
      last_card      = '0;
      card_held      = 1'b0;
      miss_run_cnt   = '0;
      miss_limit_cfg = MISS_LIMIT_RST;
      reader_on      = READER_EN_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_access_table();
      test_miss_debounce();
      test_output_backpressure();
      test_random_traffic();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
